### hdl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_RISE = 2'd1,
    PH_WAIT_FALL = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2,
    ST_BUSY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_TRIG_WIDTH = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_MIN_PULSE  = 2'd2,
    REG_MAX_PULSE  = 2'd3
  } reg_idx_e;

  localparam int CfgDataW = 16;
  localparam int WidthW   = 16;
  localparam int DistW    = 11;

  localparam logic [9:0]  TrigWidthRst = 10'd10;
  localparam logic [15:0] TimeoutRst   = 16'd30000;
  localparam logic [15:0] MinPulseRst  = 16'd116;
  localparam logic [15:0] MaxPulseRst  = 16'd23200;

  // (w + 29) / 58 == ((w + 29) >> 1) / 29 == (m * 72316) >> 21 for m < 2^16
  localparam logic [16:0] DistRound = 17'd29;
  localparam logic [31:0] DistRecip = 32'd72316;
  localparam int          DistShift = 21;

  typedef struct packed {
    logic [9:0]  trig_width;
    logic [15:0] timeout;
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    status_e           status;
    logic [WidthW-1:0] width;
  } res_t;

endpackage

### hdl/uer_ctrl.sv
// Measurement state machine: phase, tick counter, echo width and echo history.
module uer_ctrl #(
  parameter int CounterBits = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          start_i,
  input  logic          echo_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);

  localparam int CmpW = (CounterBits > 16) ? CounterBits : 16;
  localparam logic [CounterBits-1:0] CntMax = '1;

  uer_pkg::phase_e        phase_q, phase_d;
  logic [CounterBits-1:0] elapsed_q, elapsed_d;
  logic [CounterBits-1:0] width_q, width_d;
  logic                   echo_prev_q;

  logic [CounterBits-1:0] el_inc;
  logic [CmpW-1:0]        el_ext;
  logic [CmpW-1:0]        ew_ext;
  logic [15:0]            w;
  logic                   trig_run;
  logic                   timed_out;
  logic                   rise;
  logic                   out_rng;

  always_comb begin
    el_inc    = (elapsed_q == CntMax) ? elapsed_q : elapsed_q + 1'b1;
    el_ext    = CmpW'(el_inc);
    trig_run  = el_ext < CmpW'(cfg_i.trig_width);
    timed_out = (el_ext >= CmpW'(cfg_i.timeout)) || (el_inc == CntMax);
    rise      = echo_i && !echo_prev_q;
    ew_ext    = CmpW'(width_q);
    w         = ew_ext[15:0];
    out_rng   = (w < cfg_i.min_pulse) || (w > cfg_i.max_pulse);
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    width_d   = width_q;
    case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (start_i) begin
          phase_d   = uer_pkg::PH_WAIT_RISE;
          elapsed_d = '0;
          width_d   = '0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        elapsed_d = el_inc;
        if (rise) begin
          phase_d = uer_pkg::PH_WAIT_FALL;
          width_d = CounterBits'(1);
        end
        if (timed_out) begin
          phase_d = uer_pkg::PH_IDLE;
        end
      end
      uer_pkg::PH_WAIT_FALL: begin
        elapsed_d = el_inc;
        if (!echo_i) begin
          phase_d = uer_pkg::PH_IDLE;
        end else begin
          width_d = width_q + 1'b1;
          if (timed_out) begin
            phase_d = uer_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o = '{trigger: 1'b0, busy: 1'b0, done: 1'b0, status: uer_pkg::ST_OK,
              width: '0};
    case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (start_i) begin
          res_o.trigger = (cfg_i.trig_width != '0);
          res_o.busy    = 1'b1;
        end
      end
      uer_pkg::PH_WAIT_RISE, uer_pkg::PH_WAIT_FALL: begin
        if (phase_q == uer_pkg::PH_WAIT_FALL && !echo_i) begin
          res_o.done   = 1'b1;
          res_o.status = out_rng ? uer_pkg::ST_RANGE : uer_pkg::ST_OK;
          res_o.width  = w;
        end else if (timed_out) begin
          res_o.done   = 1'b1;
          res_o.status = uer_pkg::ST_TIMEOUT;
        end else begin
          res_o.trigger = trig_run;
          res_o.busy    = 1'b1;
          if (start_i) begin
            res_o.done   = 1'b1;
            res_o.status = uer_pkg::ST_BUSY;
          end
        end
      end
      default: begin
        res_o.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= uer_pkg::PH_IDLE;
      elapsed_q   <= '0;
      width_q     <= '0;
      echo_prev_q <= 1'b0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      width_q     <= width_d;
      echo_prev_q <= echo_i;
    end
  end

endmodule

### hdl/uer_dist.sv
// Distance in centimetres from the echo width by reciprocal multiplication.
module uer_dist (
  input  logic [uer_pkg::WidthW-1:0] width_i,
  input  logic                       en_i,
  output logic [uer_pkg::DistW-1:0]  dist_o
);

  logic [16:0] sum;
  logic [15:0] half;
  logic [31:0] prod;

  always_comb begin
    sum    = 17'(width_i) + uer_pkg::DistRound;
    half   = sum[16:1];
    prod   = 32'(half) * uer_pkg::DistRecip;
    dist_o = en_i ? prod[uer_pkg::DistShift +: uer_pkg::DistW] : '0;
  end

endmodule

### hdl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: one microsecond tick per item, one result per item.
// Two stages: the state machine step fills s1, the distance multiply feeds the output stage.
// Throughput: one item per cycle unless the output stalls.
// Reset: asynchronous, active low; clears the pipeline valids, the phase,
// counters and echo history, and loads the register reset values.
module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [uer_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        start_req_i,
  input  logic                        echo_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        trigger_level_o,
  output logic                        busy_res_o,
  output logic                        done_res_o,
  output logic [1:0]                  status_o,
  output logic [uer_pkg::WidthW-1:0]  pulse_width_us_o,
  output logic [uer_pkg::DistW-1:0]   distance_cm_o
);

  uer_pkg::cfg_t cfg_q;
  uer_pkg::res_t res;
  uer_pkg::res_t s1_q;
  uer_pkg::res_t out_q;
  logic          s1_valid_q;
  logic          out_valid_q;
  logic          out_move;
  logic          in_accept;
  logic          dist_en;
  logic [uer_pkg::DistW-1:0] dist_cm;
  logic [uer_pkg::DistW-1:0] dist_q;

  assign out_move   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_move;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_width <= uer_pkg::TrigWidthRst;
      cfg_q.timeout    <= uer_pkg::TimeoutRst;
      cfg_q.min_pulse  <= uer_pkg::MinPulseRst;
      cfg_q.max_pulse  <= uer_pkg::MaxPulseRst;
    end else if (cfg_we_i) begin
      case (uer_pkg::reg_idx_e'(cfg_idx_i))
        uer_pkg::REG_TRIG_WIDTH: cfg_q.trig_width <= cfg_data_i[9:0];
        uer_pkg::REG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        uer_pkg::REG_MIN_PULSE:  cfg_q.min_pulse  <= cfg_data_i;
        uer_pkg::REG_MAX_PULSE:  cfg_q.max_pulse  <= cfg_data_i;
        default:                 cfg_q.timeout    <= cfg_q.timeout;
      endcase
    end
  end

  uer_ctrl #(
    .CounterBits(COUNTER_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_accept),
    .start_i(start_req_i),
    .echo_i (echo_level_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign dist_en = s1_q.done && (s1_q.status == uer_pkg::ST_OK);

  uer_dist u_dist (
    .width_i(s1_q.width),
    .en_i   (dist_en),
    .dist_o (dist_cm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_move) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= res;
    end
    if (out_move && s1_valid_q) begin
      out_q  <= s1_q;
      dist_q <= dist_cm;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign trigger_level_o  = out_q.trigger;
  assign busy_res_o       = out_q.busy;
  assign done_res_o       = out_q.done;
  assign status_o         = out_q.status;
  assign pulse_width_us_o = out_q.width;
  assign distance_cm_o    = dist_q;

endmodule

### hdl/uer_checker.sv
// Port-level checks of the ultrasonic echo ranger and their binding.
module uer_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        trigger_level_o,
  input logic                        busy_res_o,
  input logic                        done_res_o,
  input logic [1:0]                  status_o,
  input logic [uer_pkg::WidthW-1:0]  pulse_width_us_o,
  input logic [uer_pkg::DistW-1:0]   distance_cm_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(pulse_width_us_o) && $stable(distance_cm_o))
    else $error("result changed while stalled");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == uer_pkg::ST_OK
      && pulse_width_us_o == '0 && distance_cm_o == '0)
    else $error("fields set without done");

  a_dist_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != uer_pkg::ST_OK |-> distance_cm_o == '0)
    else $error("distance given on failed measurement");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && status_o == uer_pkg::ST_BUSY |-> busy_res_o)
    else $error("rejected start while not busy");

  a_trig_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !trigger_level_o)
    else $error("trigger high while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

### test/testbench.sv
// Self-checking testbench for the ultrasonic echo ranger: random ticks, shadow model, scoreboard.
module testbench;

  localparam int CycleLimit = 800000;
  localparam int PhaseTicks = 85;
  localparam int DrainCycles = 6;

  typedef struct {
    logic                      trig;
    logic                      busy;
    logic                      done;
    uer_pkg::status_e          st;
    logic [15:0]               width;
    logic [uer_pkg::DistW-1:0] dist_cm;
  } ranger_res_t;

  class ranger_scoreboard;
    logic [9:0]       trig_w;
    logic [15:0]      timeout_w;
    logic [15:0]      min_w;
    logic [15:0]      max_w;
    uer_pkg::phase_e  phase;
    logic [15:0]      elapsed;
    logic [15:0]      echo_w;
    logic             echo_prev;
    logic             trig_act;
    ranger_res_t      readings_due[$];
    int               errors;

    function new();
      trig_w    = uer_pkg::TrigWidthRst;
      timeout_w = uer_pkg::TimeoutRst;
      min_w     = uer_pkg::MinPulseRst;
      max_w     = uer_pkg::MaxPulseRst;
      phase     = uer_pkg::PH_IDLE;
      elapsed   = '0;
      echo_w    = '0;
      echo_prev = 1'b0;
      trig_act  = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(uer_pkg::reg_idx_e idx, logic [15:0] data);
      case (idx)
        uer_pkg::REG_TRIG_WIDTH: trig_w = data[9:0];
        uer_pkg::REG_TIMEOUT:    timeout_w = data;
        uer_pkg::REG_MIN_PULSE:  min_w = data;
        uer_pkg::REG_MAX_PULSE:  max_w = data;
        default: ;
      endcase
    endfunction

    function void predict_tick(logic start, logic echo);
      ranger_res_t r;
      logic        prev;
      logic        ended;
      r.trig    = 1'b0;
      r.busy    = 1'b0;
      r.done    = 1'b0;
      r.st      = uer_pkg::ST_OK;
      r.width   = '0;
      r.dist_cm = '0;
      ended     = 1'b0;
      prev = echo_prev;
      echo_prev = echo;
      if (phase == uer_pkg::PH_IDLE) begin
        if (start) begin
          phase    = uer_pkg::PH_WAIT_RISE;
          elapsed  = '0;
          echo_w   = '0;
          trig_act = (trig_w != '0);
          r.trig   = trig_act;
          r.busy   = 1'b1;
        end
      end else begin
        if (elapsed != 16'hffff) elapsed = elapsed + 16'd1;
        trig_act = (elapsed < {6'd0, trig_w});
        if (phase == uer_pkg::PH_WAIT_FALL) begin
          if (echo) begin
            echo_w = echo_w + 16'd1;
          end else begin
            phase    = uer_pkg::PH_IDLE;
            trig_act = 1'b0;
            ended    = 1'b1;
            r.done   = 1'b1;
            r.width  = echo_w;
            if (echo_w < min_w || echo_w > max_w) begin
              r.st = uer_pkg::ST_RANGE;
            end else begin
              r.st      = uer_pkg::ST_OK;
              r.dist_cm = uer_pkg::DistW'(({1'b0, echo_w} + 17'd29) / 17'd58);
            end
          end
        end else if (echo && !prev) begin
          phase  = uer_pkg::PH_WAIT_FALL;
          echo_w = 16'd1;
        end
        if (!ended) begin
          if (elapsed >= timeout_w || elapsed == 16'hffff) begin
            phase    = uer_pkg::PH_IDLE;
            trig_act = 1'b0;
            r.done   = 1'b1;
            r.st     = uer_pkg::ST_TIMEOUT;
          end else begin
            r.trig = trig_act;
            r.busy = 1'b1;
            if (start) begin
              r.done = 1'b1;
              r.st   = uer_pkg::ST_BUSY;
            end
          end
        end
      end
      readings_due.push_back(r);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic trig, logic busy, logic done, logic [1:0] st,
                               logic [15:0] width, logic [uer_pkg::DistW-1:0] dist_cm);
      ranger_res_t r;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got status %0d width %0d",
                 $time, st, width);
        return;
      end
      r = readings_due.pop_front();
      check_field("trigger_level", 16'(r.trig), 16'(trig));
      check_field("busy_res", 16'(r.busy), 16'(busy));
      check_field("done_res", 16'(r.done), 16'(done));
      check_field("status", 16'(r.st), 16'(st));
      check_field("pulse_width_us", r.width, width);
      check_field("distance_cm", 16'(r.dist_cm), 16'(dist_cm));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_idx = '0;
  logic [uer_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         start_req = 1'b0;
  logic                         echo_level = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         trigger_level;
  logic                         busy_res;
  logic                         done_res;
  logic [1:0]                   status;
  logic [uer_pkg::WidthW-1:0]   pulse_width;
  logic [uer_pkg::DistW-1:0]    distance;

  ranger_scoreboard sb = new();
  bit               no_gaps = 1'b0;
  int               ticks_sent = 0;
  int               cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .start_req_i     (start_req),
    .echo_level_i    (echo_level),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .trigger_level_o (trigger_level),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .status_o        (status),
    .pulse_width_us_o(pulse_width),
    .distance_cm_o   (distance)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic stray_start();
    return $urandom_range(0, 9) == 0;
  endfunction

  // result side: random stalls, check each accepted item
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(trigger_level, busy_res, done_res, status, pulse_width, distance);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= start;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    sb.predict_tick(start, echo);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input uer_pkg::reg_idx_e idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [15:0] tw, input logic [15:0] to,
                            input logic [15:0] mn, input logic [15:0] mx);
    drain();
    write_reg(uer_pkg::REG_TRIG_WIDTH, tw);
    write_reg(uer_pkg::REG_TIMEOUT, to);
    write_reg(uer_pkg::REG_MIN_PULSE, mn);
    write_reg(uer_pkg::REG_MAX_PULSE, mx);
    cfg_we <= 1'b0;
  endtask

  task automatic run_measurement(input int delay, input int width);
    send_tick(1'b1, $urandom_range(0, 7) == 0);
    repeat (delay) send_tick(stray_start(), 1'b0);
    repeat (width) send_tick(stray_start(), 1'b1);
    send_tick(stray_start(), 1'b0);
  endtask

  task automatic run_phase(input int k);
    logic [15:0] tw, to, mn, mx, hi_bits;
    int          dmax, wlo, whi, first;
    hi_bits = 16'($urandom_range(0, 63)) << 10;
    case (k)
      0: begin
        tw = $urandom_range(1, 8); to = $urandom_range(20, 80);
        mn = $urandom_range(0, 10); mx = $urandom_range(10, 40);
        dmax = 6; wlo = 1; whi = 45;
      end
      1: begin
        tw = 0; to = 16'hffff; mn = 0; mx = 16'hffff;
        dmax = 4; wlo = 1; whi = 30;
      end
      2: begin
        tw = hi_bits | 16'd1023; to = 1; mn = 0; mx = 0;
        dmax = 2; wlo = 1; whi = 3;
      end
      3: begin
        tw = 3; to = 50; mn = 16'hffff; mx = 0;
        dmax = 4; wlo = 1; whi = 40;
      end
      4: begin
        tw = hi_bits | 16'd1000; to = 16'hffff; mn = 5; mx = 20;
        dmax = 8; wlo = 1; whi = 25;
      end
      5: begin
        tw = $urandom_range(0, 65535); to = $urandom_range(1, 100);
        mn = $urandom_range(0, 30); mx = $urandom_range(0, 60);
        dmax = 10; wlo = 1; whi = 70;
      end
      6: begin
        tw = uer_pkg::TrigWidthRst; to = uer_pkg::TimeoutRst;
        mn = uer_pkg::MinPulseRst; mx = uer_pkg::MaxPulseRst;
        dmax = 3; wlo = 110; whi = 125;
      end
      default: begin
        tw = $urandom_range(0, 20); to = $urandom_range(1, 15);
        mn = $urandom_range(0, 5); mx = $urandom_range(0, 10);
        dmax = 5; wlo = 1; whi = 12;
      end
    endcase
    set_config(tw, to, mn, mx);
    no_gaps = (k % 4 == 3);
    first = ticks_sent;
    while (ticks_sent - first < PhaseTicks) begin
      if ($urandom_range(0, 4) != 0) begin
        run_measurement($urandom_range(0, dmax), $urandom_range(wlo, whi));
        repeat ($urandom_range(0, 2)) send_tick(1'b0, $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short trigger, tight window
    set_config(16'd2, 16'd12, 16'd2, 16'd4);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    // echo already high at start needs a fresh rise; start while busy
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    // fall on the timeout tick with a start in the same tick
    send_tick(1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'b0);
    repeat (6) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    // zero trigger width and zero timeout
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    for (int p = 0; p < 10; p++) run_phase(p % 8);

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
